// File: hdl/bgi_pkg.sv
package bgi_pkg;

  // Grid geometry.
  localparam int GRID_SIZE   = 17;
  localparam int SAMPLE_STEP = 4;
  localparam int CELLS       = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W      = $clog2(CELLS);

  // Field widths of the transactions.
  localparam int OPCODE_W = 1;
  localparam int INDEX_W  = 9;
  localparam int VAL_W    = 16;
  localparam int COORD_W  = 6;
  localparam int S_DATA_W = ((INDEX_W + VAL_W + 2 * COORD_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((VAL_W + 7) / 8) * 8;

  // Coordinate split: the step is a power of two, so division is a shift.
  localparam int STEP_LOG2 = $clog2(SAMPLE_STEP);
  localparam int CELL_W    = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;
  localparam int FRAC_W    = $clog2(SAMPLE_STEP + 1);
  localparam int COORD_LIM = (GRID_SIZE - 1) * SAMPLE_STEP;

  // Blend arithmetic.
  localparam int A_W     = VAL_W + FRAC_W + 1;
  localparam int ACC_W   = A_W + FRAC_W + 2;
  localparam int ROUND   = (SAMPLE_STEP * SAMPLE_STEP) / 2;
  localparam int VAL_MAX = 2 ** (VAL_W - 1) - 1;
  localparam int VAL_MIN = -(2 ** (VAL_W - 1));

  // Result queue sizing: every query in flight holds a slot.
  localparam int OUT_DEPTH = 8;
  localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

  // Operation codes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Control of a query on its way from the grid reads to the blend.
  typedef struct packed {
    logic              valid;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
  } query_t;

  // The four corner samples of one cell.
  typedef struct packed {
    logic signed [VAL_W-1:0] s00;
    logic signed [VAL_W-1:0] s01;
    logic signed [VAL_W-1:0] s10;
    logic signed [VAL_W-1:0] s11;
  } corners_t;

endpackage

// File: hdl/bilinear_grid_interpolator_top.sv
// Bilinear interpolator over a square grid of Q1.15 samples.
// Input transactions arrive on the s_ group. s_tuser carries the opcode:
// a load writes grid_value at grid_index (indexes past the grid are
// dropped) and gives no result; a query blends the four corners of the
// cell holding (block_x, block_z) and gives one result on the m_ group.
// One transaction is taken per cycle while s_tready is high, loads and queries mixed freely;
// the rate is set by the two copies of the grid, each with two read
// ports, so all four corners are read in a single cycle.
// A query's result is offered on m_tvalid once it has passed the registers after the edge
// that accepts it (the corners are read at that edge): x blend, z blend
// with rounding, then the write into the result queue.
// Results wait in an eight-entry queue. While the receiver stalls the
// block keeps taking transactions until eight queries are queued or in
// flight, then drops s_tready; loads also wait at that point.
// Reset clears the pipeline and the queue. The grid itself
// is not cleared: every sample a query touches must be loaded first.
module bilinear_grid_interpolator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: grid_index[8:0], grid_value[24:9], block_x[30:25],
  // block_z[36:31], zero fill [39:37]
  input  logic [bgi_pkg::S_DATA_W-1:0]  s_tdata,
  // s_tuser: opcode[0]
  input  logic [bgi_pkg::OPCODE_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: value[15:0]
  output logic [bgi_pkg::M_DATA_W-1:0]  m_tdata
);
  import bgi_pkg::*;

  logic [INDEX_W-1:0] grid_index;
  logic [VAL_W-1:0]   grid_value;
  logic [COORD_W-1:0] block_x;
  logic [COORD_W-1:0] block_z;
  logic               accept;
  logic               q_accept;
  logic               ld_write;
  logic [CELL_W-1:0]  ix;
  logic [CELL_W-1:0]  iz;
  logic [FRAC_W-1:0]  fx;
  logic [FRAC_W-1:0]  fz;
  logic [ADDR_W-1:0]  raddr_top0;
  logic [ADDR_W-1:0]  raddr_top1;
  logic [ADDR_W-1:0]  raddr_bot0;
  logic [ADDR_W-1:0]  raddr_bot1;
  query_t             query;
  corners_t           corners;
  logic               res_valid;
  logic signed [VAL_W-1:0] res_value;
  logic               pop;
  logic [VAL_W-1:0]   value;
  logic [OCC_W-1:0]   occ;

  // Saturate a coordinate, then split it into cell and fraction. The last
  // grid line is taken as the far edge of the cell before it.
  function automatic logic [CELL_W+FRAC_W-1:0] split_coord(
    input logic [COORD_W-1:0] coord
  );
    logic [COORD_W-1:0] sat;
    logic [CELL_W-1:0]  cell_idx;
    logic [FRAC_W-1:0]  frac;
    if (32'(coord) > COORD_LIM) begin
      sat = COORD_W'(COORD_LIM);
    end else begin
      sat = coord;
    end
    cell_idx = CELL_W'(sat >> STEP_LOG2);
    frac     = FRAC_W'(sat & COORD_W'(SAMPLE_STEP - 1));
    if (32'(cell_idx) >= GRID_SIZE - 1) begin
      cell_idx = CELL_W'(GRID_SIZE - 2);
      frac     = FRAC_W'(SAMPLE_STEP);
    end
    return {cell_idx, frac};
  endfunction

  // Unpack the input transaction.
  assign grid_index = s_tdata[INDEX_W-1:0];
  assign grid_value = s_tdata[INDEX_W+VAL_W-1:INDEX_W];
  assign block_x    = s_tdata[INDEX_W+VAL_W+COORD_W-1:INDEX_W+VAL_W];
  assign block_z    = s_tdata[INDEX_W+VAL_W+2*COORD_W-1:INDEX_W+VAL_W+COORD_W];

  assign s_tready = (occ < OCC_W'(OUT_DEPTH));
  assign accept   = s_tvalid && s_tready;
  assign q_accept = accept && (s_tuser == OP_QUERY);
  assign ld_write = accept && (s_tuser == OP_LOAD) && (32'(grid_index) < CELLS);

  // Corner addresses: top row in one grid copy, bottom row in the other.
  always_comb begin
    {ix, fx}   = split_coord(block_x);
    {iz, fz}   = split_coord(block_z);
    raddr_top0 = ADDR_W'(int'(iz) * GRID_SIZE + int'(ix));
    raddr_top1 = ADDR_W'(int'(iz) * GRID_SIZE + int'(ix) + 1);
    raddr_bot0 = ADDR_W'((int'(iz) + 1) * GRID_SIZE + int'(ix));
    raddr_bot1 = ADDR_W'((int'(iz) + 1) * GRID_SIZE + int'(ix) + 1);
  end

  bgi_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CELLS)
  ) u_ram_top (
    .clk   (clk),
    .we    (ld_write),
    .waddr (ADDR_W'(grid_index)),
    .wdata (grid_value),
    .raddr0(raddr_top0),
    .raddr1(raddr_top1),
    .rdata0(corners.s00),
    .rdata1(corners.s01)
  );

  bgi_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CELLS)
  ) u_ram_bot (
    .clk   (clk),
    .we    (ld_write),
    .waddr (ADDR_W'(grid_index)),
    .wdata (grid_value),
    .raddr0(raddr_bot0),
    .raddr1(raddr_bot1),
    .rdata0(corners.s10),
    .rdata1(corners.s11)
  );

  // Fractions travel alongside the grid read.
  always_ff @(posedge clk) begin
    if (rst) begin
      query.valid <= 1'b0;
    end else begin
      query.valid <= q_accept;
    end
    query.fx <= fx;
    query.fz <= fz;
  end

  bgi_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .query    (query),
    .corners  (corners),
    .res_valid(res_valid),
    .res_value(res_value)
  );

  assign pop = m_tvalid && m_tready;

  bgi_out_fifo u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (res_valid),
    .din  (res_value),
    .pop  (pop),
    .valid(m_tvalid),
    .dout (value)
  );

  assign m_tdata = M_DATA_W'(value);

  // Queries in flight plus results waiting; bounds the queue fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(q_accept) - OCC_W'(pop);
    end
  end

  // The occupancy count never passes the queue depth.
  assert property (@(posedge clk) disable iff (rst) occ <= OCC_W'(OUT_DEPTH))
    else $error("query occupancy exceeds the result queue depth");

  // Every accepted query reaches the end of the blend through the query, x blend and z blend registers.
  assert property (@(posedge clk) disable iff (rst) q_accept |-> ##3 res_valid)
    else $error("accepted query did not leave the blend pipeline on time");

  // A result offered downstream is always counted as outstanding.
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> occ != '0)
    else $error("result offered with no outstanding query");

  // Loads never start a blend.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser == OP_LOAD)) |=> !query.valid)
    else $error("load transaction entered the blend pipeline");

endmodule

// File: hdl/bgi_ram.sv
module bgi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 289
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: hdl/bgi_blend.sv
module bgi_blend (
  input  logic                            clk,
  input  logic                            rst,
  input  bgi_pkg::query_t                 query,
  input  bgi_pkg::corners_t               corners,
  output logic                            res_valid,
  output logic signed [bgi_pkg::VAL_W-1:0] res_value
);
  import bgi_pkg::*;

  logic                    a_valid;
  logic signed [A_W-1:0]   a_top;
  logic signed [A_W-1:0]   a_bot;
  logic [FRAC_W-1:0]       a_fz;
  logic signed [A_W-1:0]   a_top_next;
  logic signed [A_W-1:0]   a_bot_next;
  logic [FRAC_W-1:0]       wx0;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] quot;
  logic [FRAC_W-1:0]       wz0;
  logic signed [VAL_W-1:0] res_value_next;

  // Blend along x: weights are step minus fraction and fraction.
  always_comb begin
    wx0        = FRAC_W'(SAMPLE_STEP) - query.fx;
    a_top_next = A_W'(corners.s00) * A_W'($signed({1'b0, wx0}))
               + A_W'(corners.s01) * A_W'($signed({1'b0, query.fx}));
    a_bot_next = A_W'(corners.s10) * A_W'($signed({1'b0, wx0}))
               + A_W'(corners.s11) * A_W'($signed({1'b0, query.fx}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= query.valid;
    end
    a_top <= a_top_next;
    a_bot <= a_bot_next;
    a_fz  <= query.fz;
  end

  // Blend along z, add half an output step, floor by the squared step and saturate.
  always_comb begin
    wz0  = FRAC_W'(SAMPLE_STEP) - a_fz;
    acc  = ACC_W'(a_top) * ACC_W'($signed({1'b0, wz0}))
         + ACC_W'(a_bot) * ACC_W'($signed({1'b0, a_fz}))
         + ACC_W'(ROUND);
    quot = acc >>> (2 * STEP_LOG2);
    if (quot > ACC_W'(VAL_MAX)) begin
      res_value_next = VAL_W'(VAL_MAX);
    end else if (quot < ACC_W'(VAL_MIN)) begin
      res_value_next = VAL_W'(VAL_MIN);
    end else begin
      res_value_next = quot[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= a_valid;
    end
    res_value <= res_value_next;
  end

endmodule

// File: hdl/bgi_out_fifo.sv
module bgi_out_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [bgi_pkg::VAL_W-1:0] din,
  input  logic                     pop,
  output logic                     valid,
  output logic [bgi_pkg::VAL_W-1:0] dout
);
  import bgi_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);

  logic [VAL_W-1:0] slots [OUT_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [OCC_W-1:0] count;

  // Pointers and fill count; the caller never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + OCC_W'(push) - OCC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  assign valid = (count != '0);
  assign dout  = slots[rptr];

endmodule
